/* rtl/grr_pkg.sv */
// ----------------------------------------------------------------------------
// grr_pkg
// Shared types and constants for the group reverse reorder block.
// ----------------------------------------------------------------------------
package grr_pkg;

   localparam int MAX_GROUP = 16;
   localparam int DATA_W    = 32;
   localparam int CNT_W     = $clog2(MAX_GROUP + 1);
   localparam int IDX_W     = $clog2(MAX_GROUP);
   localparam int SIZE_W    = 5;

   typedef logic signed [DATA_W-1:0] data_type;
   typedef logic [CNT_W-1:0]         cnt_type;
   typedef logic [IDX_W-1:0]         idx_type;

   typedef enum logic {
      ST_LOAD,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic    shift_up;
      logic    shift_down;
      idx_type rd_idx;
   } chain_ctl_type;

endpackage

/* rtl/grr_req_if.sv */
// ----------------------------------------------------------------------------
// grr_req_if
// Input channel: one sequence element per transfer.
// ----------------------------------------------------------------------------
interface grr_req_if;
   logic                   valid;
   logic                   ready;
   logic signed [31:0]     value;
   logic                   seq_end;

   modport source (output valid, output value, output seq_end, input ready);
   modport sink   (input valid, input value, input seq_end, output ready);
endinterface

/* rtl/grr_rsp_if.sv */
// ----------------------------------------------------------------------------
// grr_rsp_if
// Result channel: one reordered element per transfer.
// ----------------------------------------------------------------------------
interface grr_rsp_if;
   logic                   valid;
   logic                   ready;
   logic signed [31:0]     out_value;
   logic                   run_end;
   logic                   out_seq_end;

   modport source (output valid, output out_value, output run_end, output out_seq_end,
                   input ready);
   modport sink   (input valid, input out_value, input run_end, input out_seq_end,
                   output ready);
endinterface

/* rtl/grr_cell.sv */
// ----------------------------------------------------------------------------
// grr_cell
// One storage cell of the element chain; loads from either neighbor.
// ----------------------------------------------------------------------------
module grr_cell (
   input  logic              clock,
   input  logic              shift_up,
   input  logic              shift_down,
   input  grr_pkg::data_type from_below,
   input  grr_pkg::data_type from_above,
   output grr_pkg::data_type data_out
);

   grr_pkg::data_type data_ff;
   grr_pkg::data_type data_in;

   always_comb begin
      data_in = data_ff;
      if (shift_up) begin
         data_in = from_below;
      end else if (shift_down) begin
         data_in = from_above;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_out = data_ff;

endmodule

/* rtl/grr_chain.sv */
// ----------------------------------------------------------------------------
// grr_chain
// Row of cells; newest element at cell 0, pops toward cell 0.
// ----------------------------------------------------------------------------
module grr_chain (
   input  logic                  clock,
   input  grr_pkg::chain_ctl_type ctl,
   input  grr_pkg::data_type     in_data,
   output grr_pkg::data_type     head_data,
   output grr_pkg::data_type     sel_data
);

   grr_pkg::data_type cell_q [grr_pkg::MAX_GROUP];

   for (genvar i = 0; i < grr_pkg::MAX_GROUP; i++) begin : g_cell
      grr_pkg::data_type below;
      grr_pkg::data_type above;

      if (i == 0) begin : g_first
         assign below = in_data;
      end else begin : g_mid
         assign below = cell_q[i-1];
      end

      if (i == grr_pkg::MAX_GROUP - 1) begin : g_last
         assign above = '0;
      end else begin : g_up
         assign above = cell_q[i+1];
      end

      grr_cell u_cell (
         .clock      (clock),
         .shift_up   (ctl.shift_up),
         .shift_down (ctl.shift_down),
         .from_below (below),
         .from_above (above),
         .data_out   (cell_q[i])
      );
   end

   assign head_data = cell_q[0];
   assign sel_data  = cell_q[ctl.rd_idx];

endmodule

/* rtl/grr_ctrl.sv */
// ----------------------------------------------------------------------------
// grr_ctrl
// Fill counter, group size register and load/emit sequencing.
// ----------------------------------------------------------------------------
module grr_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   grr_req_if.sink                req_if,
   grr_rsp_if.source              rsp_if,
   input  logic                   csr_wr_en,
   input  logic [grr_pkg::SIZE_W-1:0] csr_wr_data,
   input  grr_pkg::data_type      head_data,
   input  grr_pkg::data_type      sel_data,
   output grr_pkg::chain_ctl_type ctl
);

   grr_pkg::state_type        state_ff, state_in;
   grr_pkg::cnt_type          fill_ff, fill_in;
   logic                      reverse_ff, reverse_in;
   logic                      send_ff, send_in;
   logic [grr_pkg::SIZE_W-1:0] size_ff, size_in;

   grr_pkg::cnt_type eff_size;
   grr_pkg::cnt_type stored_cnt;
   logic             req_xfer;
   logic             rsp_xfer;
   logic             has_room;

   assign size_in  = csr_wr_en ? csr_wr_data : size_ff;
   assign req_xfer = req_if.valid && req_if.ready;
   assign rsp_xfer = rsp_if.valid && rsp_if.ready;
   assign has_room = fill_ff < grr_pkg::CNT_W'(grr_pkg::MAX_GROUP);

   always_comb begin
      if (size_ff == '0) begin
         eff_size = grr_pkg::CNT_W'(1);
      end else if (grr_pkg::CNT_W'(size_ff) > grr_pkg::CNT_W'(grr_pkg::MAX_GROUP)) begin
         eff_size = grr_pkg::CNT_W'(grr_pkg::MAX_GROUP);
      end else begin
         eff_size = grr_pkg::CNT_W'(size_ff);
      end
   end

   assign stored_cnt = has_room ? fill_ff + grr_pkg::CNT_W'(1) : fill_ff;

   // next state
   always_comb begin
      state_in   = state_ff;
      fill_in    = fill_ff;
      reverse_in = reverse_ff;
      send_in    = send_ff;
      case (state_ff)
         grr_pkg::ST_LOAD: begin
            if (req_xfer) begin
               fill_in = stored_cnt;
               send_in = req_if.seq_end;
               if (stored_cnt >= eff_size) begin
                  reverse_in = 1'b1;
                  state_in   = grr_pkg::ST_EMIT;
               end else if (req_if.seq_end) begin
                  reverse_in = 1'b0;
                  state_in   = grr_pkg::ST_EMIT;
               end
            end
         end
         grr_pkg::ST_EMIT: begin
            if (rsp_xfer) begin
               fill_in = fill_ff - grr_pkg::CNT_W'(1);
               if (fill_ff == grr_pkg::CNT_W'(1)) begin
                  state_in = grr_pkg::ST_LOAD;
               end
            end
         end
         default: begin
            state_in = grr_pkg::ST_LOAD;
            fill_in  = '0;
         end
      endcase
   end

   // outputs
   always_comb begin
      req_if.ready       = 1'b0;
      rsp_if.valid       = 1'b0;
      ctl.shift_up       = 1'b0;
      ctl.shift_down     = 1'b0;
      ctl.rd_idx         = grr_pkg::IDX_W'(fill_ff - grr_pkg::CNT_W'(1));
      rsp_if.out_value   = reverse_ff ? head_data : sel_data;
      rsp_if.run_end     = fill_ff == grr_pkg::CNT_W'(1);
      rsp_if.out_seq_end = (fill_ff == grr_pkg::CNT_W'(1)) && send_ff;
      case (state_ff)
         grr_pkg::ST_LOAD: begin
            req_if.ready = 1'b1;
            ctl.shift_up = req_if.valid && has_room;
         end
         grr_pkg::ST_EMIT: begin
            rsp_if.valid   = 1'b1;
            ctl.shift_down = rsp_if.ready && reverse_ff;
         end
         default: begin
            req_if.ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= grr_pkg::ST_LOAD;
         fill_ff    <= '0;
         reverse_ff <= 1'b0;
         send_ff    <= 1'b0;
         size_ff    <= grr_pkg::SIZE_W'(1);
      end else begin
         state_ff   <= state_in;
         fill_ff    <= fill_in;
         reverse_ff <= reverse_in;
         send_ff    <= send_in;
         size_ff    <= size_in;
      end
   end

   a_emit_nonempty: assert property (@(posedge clock) disable iff (reset)
      state_ff == grr_pkg::ST_EMIT |-> fill_ff != '0)
      else $error("emitting with empty chain");

   a_load_room: assert property (@(posedge clock) disable iff (reset)
      state_ff == grr_pkg::ST_LOAD |-> fill_ff < grr_pkg::CNT_W'(grr_pkg::MAX_GROUP))
      else $error("chain full while loading");

   a_one_side: assert property (@(posedge clock) disable iff (reset)
      !(req_if.ready && rsp_if.valid))
      else $error("input and result sides open together");

   a_run_done: assert property (@(posedge clock) disable iff (reset)
      rsp_xfer && rsp_if.run_end |=> state_ff == grr_pkg::ST_LOAD && fill_ff == '0)
      else $error("run end did not empty the chain");

endmodule

/* rtl/group_reverse_reorder_top.sv */
// ----------------------------------------------------------------------------
// group_reverse_reorder_top
// Reverses a stream of signed words in groups of a programmable size.
//
//   channel  dir  handshake        payload
//   req_if   in   valid/ready      value, seq_end
//   rsp_if   out  valid/ready      out_value, run_end, out_seq_end
//   csr      in   csr_wr_en        csr_wr_data (group size)
//
// Each element shifts into the cell chain on an input transfer and leaves it
// on a result transfer. A group cut short by seq_end leaves in arrival order.
// Input and output phases alternate; no input is taken while a group drains.
// Synchronous reset empties the chain and sets the group size to one.
// A stalled result holds its payload; cells do not move until transfer.
// ----------------------------------------------------------------------------
module group_reverse_reorder_top (
   input  logic                       clock,
   input  logic                       reset,
   grr_req_if.sink                    req_if,
   grr_rsp_if.source                  rsp_if,
   input  logic                       csr_wr_en,
   input  logic [grr_pkg::SIZE_W-1:0] csr_wr_data
);

   grr_pkg::chain_ctl_type ctl;
   grr_pkg::data_type      head_data;
   grr_pkg::data_type      sel_data;

   grr_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .rsp_if      (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .head_data   (head_data),
      .sel_data    (sel_data),
      .ctl         (ctl)
   );

   grr_chain u_chain (
      .clock     (clock),
      .ctl       (ctl),
      .in_data   (req_if.value),
      .head_data (head_data),
      .sel_data  (sel_data)
   );

endmodule
